>>> rtl/core/mbenc_pkg.sv
// ----------------------------------------------------------------------------
// mbenc_pkg: shared types and constants of the Modbus request frame encoder
// Request and frame byte structs, framing mode and request kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbenc_pkg;

	typedef struct packed {
		logic        kind;
		logic [7:0]  unit_id;
		logic [7:0]  req_code;
		logic [15:0] target_address;
		logic [15:0] operand_word;
	} mbenc_req_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} mbenc_byte_t;

	localparam logic MODE_RTU = 1'b0;
	localparam logic MODE_TCP = 1'b1;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [7:0] CODE_WRITE_COIL = 8'd5;
	localparam logic [7:0] CODE_WRITE_REG  = 8'd6;

	localparam logic [15:0] WRITE_SCALE = 16'd10000;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] COIL_ON     = 16'hFF00;
	localparam logic [7:0]  MBAP_LEN    = 8'd6;

	localparam int          IDX_W     = 4;
	localparam logic [3:0]  RTU_LAST  = 4'd7;
	localparam logic [3:0]  TCP_LAST  = 4'd11;

endpackage

`default_nettype wire

>>> rtl/core/modbus_request_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// modbus_request_frame_encoder_core: Modbus RTU/TCP request frame encoder
// Turns one read or write request into its frame, one byte per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the item is taken at a
//   rising edge with start high and busy low.
//   Config channel: cfg_data (framing mode, 0 = RTU, 1 = TCP) is written at
//   an edge with cfg_valid and cfg_ready high; cfg_ready is always high.
//   Write it only while no frame is in flight. The mode is sampled when an
//   item is taken.
//   Result channel: each frame byte shows on result for exactly one cycle
//   with strobe high; result.last_byte marks the final byte. The receiver
//   cannot stall it.
//   Timing: the request is captured into req_s1 at the accepting edge,
//   and each byte is then registered into result before it shows.
//   Throughput: one byte per cycle; a frame is 8 bytes in RTU mode and 12
//   in TCP mode. busy drops while the last byte is being registered into
//   result, so the next frame follows with no gap.
//   The CRC-16 is accumulated one byte per cycle while bytes go out.
//   Reset clears the mode to RTU, drops busy and strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_request_frame_encoder_core
	import mbenc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire mbenc_req_t  request,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	output logic             strobe,
	output mbenc_byte_t      result
);

	logic             mode_q;
	mbenc_req_t       req_s1;
	logic             mode_s1;
	logic             active_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [15:0]      crc_q;
	mbenc_byte_t      result_q;
	logic             strobe_q;

	logic             accept;
	logic             is_last;
	logic [2:0]       wcode;
	logic [15:0]      scaled;
	logic [15:0]      rem;
	logic [7:0]       code;
	logic [15:0]      reg_addr;
	logic [15:0]      val;
	logic [7:0]       cur_byte;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RTU;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign is_last = (mode_s1 == MODE_TCP) ? (idx_s1 == TCP_LAST) : (idx_s1 == RTU_LAST);
	assign busy    = active_s1 && !is_last;
	assign accept  = start && !busy;

	// Decimal decode of the write address: quotient 0..6 by compares
	always_comb begin
		wcode = 3'd0;
		for (int k = 1; k <= 6; k++) begin
			if ({16'd0, req_s1.target_address} >= k * 32'(WRITE_SCALE)) begin
				wcode = 3'(k);
			end
		end
		scaled = 16'(32'(wcode) * 32'(WRITE_SCALE));
		rem    = req_s1.target_address - scaled;
	end

	always_comb begin
		if (req_s1.kind == KIND_READ) begin
			code     = req_s1.req_code;
			reg_addr = req_s1.target_address;
			val      = req_s1.operand_word;
		end else begin
			code     = {5'd0, wcode};
			reg_addr = rem - 16'd1;
			if (code == CODE_WRITE_COIL) begin
				val = (req_s1.operand_word == 16'd1) ? COIL_ON : 16'd0;
			end else if (code == CODE_WRITE_REG) begin
				val = req_s1.operand_word;
			end else begin
				val = 16'd0;
			end
		end
	end

	always_comb begin
		cur_byte = 8'd0;
		if (mode_s1 == MODE_RTU) begin
			case (idx_s1)
				4'd0:    cur_byte = req_s1.unit_id;
				4'd1:    cur_byte = code;
				4'd2:    cur_byte = reg_addr[15:8];
				4'd3:    cur_byte = reg_addr[7:0];
				4'd4:    cur_byte = val[15:8];
				4'd5:    cur_byte = val[7:0];
				4'd6:    cur_byte = crc_q[7:0];
				4'd7:    cur_byte = crc_q[15:8];
				default: cur_byte = 8'd0;
			endcase
		end else begin
			case (idx_s1)
				4'd5:    cur_byte = MBAP_LEN;
				4'd6:    cur_byte = req_s1.unit_id;
				4'd7:    cur_byte = code;
				4'd8:    cur_byte = reg_addr[15:8];
				4'd9:    cur_byte = reg_addr[7:0];
				4'd10:   cur_byte = val[15:8];
				4'd11:   cur_byte = val[7:0];
				default: cur_byte = 8'd0;
			endcase
		end
	end

	// Hold the item, advance the byte index each cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
			idx_s1    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= active_s1;
			if (accept) begin
				active_s1 <= 1'b1;
				idx_s1    <= '0;
			end else if (active_s1) begin
				if (is_last) begin
					active_s1 <= 1'b0;
				end
				idx_s1 <= idx_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= request;
			mode_s1 <= mode_q;
			crc_q   <= CRC_INIT;
		end else if (active_s1 && idx_s1 < 4'd6) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
		result_q.frame_byte <= cur_byte;
		result_q.last_byte  <= is_last;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire
